// ===== rtl/hhws_pkg.sv =====
// Hex hash window scanner package: item types, character codes and the hex digit decoder.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package hhws_pkg;

	// Window geometry
	localparam int unsigned WinDigits = 64;
	localparam int unsigned DigitW    = 4;
	localparam int unsigned WinW      = WinDigits * DigitW;
	localparam int unsigned RunW      = 6;
	localparam logic [RunW-1:0] RunMax = 6'd63;

	// ASCII codes that bound the accepted digit ranges
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLoA   = 8'h61;
	localparam logic [7:0] ChLoF   = 8'h66;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] LetterOfs = 8'd10;

	typedef struct packed {
		logic [7:0] byte_in;
	} in_item_t;

	// word0 sits in the top bits, so the window vector maps straight onto it
	typedef struct packed {
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [31:0] word3;
		logic [31:0] word4;
		logic [31:0] word5;
		logic [31:0] word6;
		logic [31:0] word7;
	} out_item_t;

	typedef struct packed {
		logic              is_hex;
		logic [DigitW-1:0] val;
	} hex_dec_t;

	// Decode one byte: 0-9, a-f and A-F only
	function automatic hex_dec_t hex_decode(input logic [7:0] b);
		hex_dec_t   d;
		logic [7:0] diff;
		d    = '0;
		diff = '0;
		if (b >= ChZero && b <= ChNine) begin
			diff     = b - ChZero;
			d.is_hex = 1'b1;
		end else if (b >= ChLoA && b <= ChLoF) begin
			diff     = b - ChLoA + LetterOfs;
			d.is_hex = 1'b1;
		end else if (b >= ChUpA && b <= ChUpF) begin
			diff     = b - ChUpA + LetterOfs;
			d.is_hex = 1'b1;
		end
		d.val = diff[DigitW-1:0];
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hhws_if.sv =====
// Valid/ready channel interface carrying one item of a given payload type.
// Used by the scanner top level for its byte input and hash output.
`default_nettype none

interface hhws_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/hex_hash_window_scanner.sv =====
// Hex hash window scanner top level: input byte register, 64-digit window, result register.
// Depends on hhws_pkg (types, decoder) and hhws_if (channels).
//
//  channel   dir  payload                   meaning
//  byte_ch   in   byte_in [7:0]             one raw byte of the text stream
//  hash_ch   out  word0..word7 [31:0] each  256-bit candidate, oldest digits in word0
//
// One byte per cycle unless output stalls: registered on acceptance, then decoded/shifted.
// The 64th (or later) contiguous hex digit shifted in loads the result register.
// Reset clears the window, the run count and both valid flags.
// A stalled output holds its result; input keeps flowing while the input register can move.
`default_nettype none

module hex_hash_window_scanner (
	input  wire logic clk,
	input  wire logic arst_n,
	hhws_if.sink      byte_ch,
	hhws_if.source    hash_ch
);
	import hhws_pkg::*;

	logic               vld_s1;
	logic [7:0]         byte_s1;
	logic [WinW-1:0]    window_q;
	logic [RunW-1:0]    run_q;
	logic               vld_s2;
	out_item_t          hash_s2;

	logic               advance;
	logic               process;
	logic               emit;
	hex_dec_t           dec;
	logic [WinW-1:0]    win_nxt;

	// Handshake: input register moves when output slot is free or being drained
	assign advance       = !vld_s2 || hash_ch.ready;
	assign byte_ch.ready = !vld_s1 || advance;
	assign process       = vld_s1 && advance;

	// Decode and shift
	assign dec     = hex_decode(byte_s1);
	assign win_nxt = {window_q[WinW-DigitW-1:0], dec.val};
	assign emit    = process && dec.is_hex && (run_q == RunMax);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data.byte_in;
		end
	end

	// Window and saturating run count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			run_q    <= '0;
		end else if (process) begin
			if (!dec.is_hex) begin
				run_q <= '0;
			end else begin
				window_q <= win_nxt;
				if (run_q != RunMax) begin
					run_q <= run_q + 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (emit) begin
			vld_s2 <= 1'b1;
		end else if (hash_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hash_s2 <= out_item_t'(win_nxt);
		end
	end

	assign hash_ch.valid = vld_s2;
	assign hash_ch.data  = hash_s2;

`ifndef SYNTHESIS
	// A result is only produced from a full run
	a_emit_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> run_q == RunMax)
		else $error("result emitted before 64 contiguous digits");

	// Non-hex byte clears the run
	a_nonhex_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(process && !dec.is_hex) |=> run_q == '0)
		else $error("run count not cleared by non-hex byte");

	// Hex byte below saturation counts up by one
	a_run_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(process && dec.is_hex && run_q != RunMax) |=> run_q == $past(run_q) + 1'b1)
		else $error("run count did not advance");

	// Newest digit lands in the low nibble of word7
	a_newest_digit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> hash_s2.word7[DigitW-1:0] == $past(dec.val))
		else $error("newest digit misplaced in result");

	// A pending result is never overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !hash_ch.ready) |-> !emit)
		else $error("result overwritten during stall");
`endif

endmodule

`default_nettype wire
